// File: rtl/core/cmg_pkg.sv
// cmg_pkg: shared types, constants and the sine table builder for the cylinder mesh generator
// no dependencies; imported by every module of the block
`default_nettype none

package cmg_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS = 14;
   localparam int VAL_W     = 16;
   localparam int Z_W       = 15;
   localparam int CNT_W     = 7;
   localparam int PHASE_W   = 16;
   localparam int RAD_W     = 15;
   localparam int VIDX_W    = 14;
   localparam int MAG_W     = FRAC_BITS + 1;
   localparam int PROD_W    = RAD_W + MAG_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [RAD_W-1:0]   ONE_Q        = RAD_W'(1 << FRAC_BITS);
   localparam logic [Z_W-1:0]     HALF_Q       = Z_W'(1 << (FRAC_BITS - 1));
   localparam logic [PROD_W-1:0]  ROUND_Q      = PROD_W'(1 << (FRAC_BITS - 1));
   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1 << (PHASE_W - 2));
   localparam logic [CNT_W-1:0]   MIN_RES      = CNT_W'(3);
   localparam logic [2:0]         CORNERS      = 3'd6;
   localparam logic [2:0]         LAST_CORNER  = 3'd5;

   // mesh sections
   localparam logic [1:0] SEC_BOTTOM = 2'd0;
   localparam logic [1:0] SEC_TUBE   = 2'd1;
   localparam logic [1:0] SEC_TOP    = 2'd2;

   // result kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_STEP = 2'd2;

   localparam logic [CNT_W-1:0]   RING_COUNT_RST  = 7'd16;
   localparam logic [PHASE_W-1:0] ANGLE_STEP_RST  = 16'd4096;
   localparam logic [RAD_W-1:0]   RADIUS_STEP_RST = 15'd1092;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // one classified item on its way from the sequencer to the datapath
   typedef struct packed {
      logic               valid_res;
      logic               kind;
      logic               last;
      logic [1:0]         section;
      logic [CNT_W-1:0]   ring;
      logic [CNT_W-1:0]   sector;
      logic [CNT_W-1:0]   n;
      logic [2:0]         corner;
      logic [PHASE_W-1:0] phase;
      logic [RAD_W-1:0]   radius;
   } cmd_type;

   // sine table entry k of a quarter wave with 2^tbits steps, Q30 series, rounded to Q1.14
   function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] v;
      x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int unsigned n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > (64'd1 << 31)) begin
         sum = 64'd0;
      end
      v = ((sum << FRAC_BITS) + (64'd1 << 29)) >> 30;
      if (v > 64'(ONE_Q)) begin
         v = 64'(ONE_Q);
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/cmg_queue.sv
// cmg_queue: two-entry command queue between sequencer and datapath
// depends on cmg_pkg (cmd_type)
`default_nettype none

module cmg_queue import cmg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   cmd_type    entry0_ff, entry1_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = rd_ptr_ff ? entry1_ff : entry0_ff;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !wr_ptr_ff) begin
         entry0_ff <= push_cmd;
      end
      if (push && wr_ptr_ff) begin
         entry1_ff <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/cmg_front.sv
// cmg_front: accepts items and walks the section, ring, sector and corner counters
// depends on cmg_pkg; feeds one cmd_type per transfer into cmg_queue
`default_nettype none

module cmg_front import cmg_pkg::*; #(
   parameter int MAX_RES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_restart,
   input  wire logic [CNT_W-1:0]   ring_count,
   input  wire logic [PHASE_W-1:0] angle_step,
   input  wire logic [RAD_W-1:0]   radius_step,
   input  wire logic               queue_full,
   output logic                    push,
   output cmd_type                 push_cmd
);

   localparam int RES_CAP = (MAX_RES > 127) ? 127 : MAX_RES;
   localparam logic [CNT_W-1:0] RES_CAP_W = CNT_W'(RES_CAP);

   logic [1:0]         section_ff, section_in, eff_section;
   logic [CNT_W-1:0]   ring_ff, ring_in, eff_ring;
   logic [CNT_W-1:0]   sector_ff, sector_in, eff_sector;
   logic [2:0]         corner_ff, corner_in, eff_corner;
   logic [PHASE_W-1:0] phase_ff, phase_in, eff_phase;
   logic [RAD_W-1:0]   radius_ff, radius_in, eff_radius;
   logic               index_ff, index_in, eff_index;
   logic               fin_ff, fin_in, eff_fin;

   logic [CNT_W-1:0]   n;
   logic [CNT_W-1:0]   rows;
   logic [CNT_W:0]     sector_n, ring_n;
   logic [2:0]         corner_n;
   logic [RAD_W:0]     radius_sum;
   logic [RAD_W-1:0]   radius_sat;
   logic               wrap_sector;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // resolution clamp
   always_comb begin
      if (ring_count < MIN_RES) begin
         n = MIN_RES;
      end else if (ring_count > RES_CAP_W) begin
         n = RES_CAP_W;
      end else begin
         n = ring_count;
      end
   end

   always_comb begin
      // restart takes effect before the item is classified
      if (req_restart) begin
         eff_section = SEC_BOTTOM;
         eff_ring    = '0;
         eff_sector  = '0;
         eff_corner  = '0;
         eff_phase   = '0;
         eff_radius  = '0;
         eff_index   = 1'b0;
         eff_fin     = 1'b0;
      end else begin
         eff_section = section_ff;
         eff_ring    = ring_ff;
         eff_sector  = sector_ff;
         eff_corner  = corner_ff;
         eff_phase   = phase_ff;
         eff_radius  = radius_ff;
         eff_index   = index_ff;
         eff_fin     = fin_ff;
      end

      push_cmd           = '0;
      push_cmd.valid_res = !eff_fin;
      push_cmd.kind      = eff_fin ? KIND_VERTEX : eff_index;
      push_cmd.section   = eff_section;
      push_cmd.ring      = eff_ring;
      push_cmd.sector    = eff_sector;
      push_cmd.corner    = eff_corner;
      push_cmd.phase     = eff_phase;
      push_cmd.radius    = eff_radius;
      push_cmd.n         = n;
      push_cmd.last      = !eff_fin && eff_index && (eff_section == SEC_TOP)
                           && ({1'b0, eff_ring} + 8'd2 >= {1'b0, n})
                           && ({1'b0, eff_sector} + 8'd1 >= {1'b0, n})
                           && (eff_corner == LAST_CORNER);

      if (eff_index) begin
         rows = (eff_section == SEC_TUBE) ? CNT_W'(1) : n - CNT_W'(1);
      end else begin
         rows = (eff_section == SEC_TUBE) ? CNT_W'(2) : n;
      end
      sector_n   = {1'b0, eff_sector} + 8'd1;
      ring_n     = {1'b0, eff_ring} + 8'd1;
      corner_n   = eff_corner + 3'd1;
      radius_sum = {1'b0, eff_radius} + {1'b0, radius_step};
      radius_sat = (radius_sum > {1'b0, ONE_Q}) ? ONE_Q : radius_sum[RAD_W-1:0];

      section_in  = eff_section;
      ring_in     = eff_ring;
      sector_in   = eff_sector;
      corner_in   = eff_corner;
      phase_in    = eff_phase;
      radius_in   = eff_radius;
      index_in    = eff_index;
      fin_in      = eff_fin;
      wrap_sector = 1'b0;

      if (!eff_fin) begin
         wrap_sector = 1'b1;
         if (eff_index) begin
            if (corner_n < CORNERS) begin
               corner_in   = corner_n;
               wrap_sector = 1'b0;
            end else begin
               corner_in = '0;
            end
         end else begin
            phase_in = eff_phase + angle_step;
         end
         if (wrap_sector) begin
            if (sector_n < {1'b0, n}) begin
               sector_in = sector_n[CNT_W-1:0];
            end else begin
               sector_in = '0;
               phase_in  = '0;
               if (ring_n < {1'b0, rows}) begin
                  ring_in   = ring_n[CNT_W-1:0];
                  radius_in = radius_sat;
               end else begin
                  ring_in   = '0;
                  radius_in = '0;
                  if (eff_section != SEC_TOP) begin
                     section_in = eff_section + 2'd1;
                  end else begin
                     section_in = SEC_BOTTOM;
                     if (eff_index) begin
                        fin_in = 1'b1;
                     end else begin
                        index_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= SEC_BOTTOM;
         ring_ff    <= '0;
         sector_ff  <= '0;
         corner_ff  <= '0;
         phase_ff   <= '0;
         radius_ff  <= '0;
         index_ff   <= 1'b0;
         fin_ff     <= 1'b1;
      end else if (push) begin
         section_ff <= section_in;
         ring_ff    <= ring_in;
         sector_ff  <= sector_in;
         corner_ff  <= corner_in;
         phase_ff   <= phase_in;
         radius_ff  <= radius_in;
         index_ff   <= index_in;
         fin_ff     <= fin_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/cmg_back.sv
// cmg_back: sine table lookup, radius scaling and index arithmetic, three stages to the output register
// depends on cmg_pkg (cmd_type, sine_entry, constants)
`default_nettype none

module cmg_back import cmg_pkg::*; #(
   parameter int TABLE_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire cmd_type           head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid_res,
   output logic                   rsp_kind,
   output logic signed [VAL_W-1:0] rsp_pos_x,
   output logic signed [VAL_W-1:0] rsp_pos_y,
   output logic signed [Z_W-1:0]   rsp_pos_z,
   output logic signed [VAL_W-1:0] rsp_norm_x,
   output logic signed [VAL_W-1:0] rsp_norm_y,
   output logic signed [VAL_W-1:0] rsp_norm_z,
   output logic [VIDX_W-1:0]       rsp_vertex_index,
   output logic                    rsp_last
);

   localparam int ROM_Q = 1 << TABLE_BITS;
   localparam int IDX_W = TABLE_BITS + 1;

   logic [MAG_W-1:0] sine_rom [0:ROM_Q];

   for (genvar k = 0; k <= ROM_Q; k++) begin : g_rom
      localparam logic [MAG_W-1:0] ENTRY = sine_entry(k, TABLE_BITS);
      assign sine_rom[k] = ENTRY;
   end

   logic adv;

   // stage 1: table reads, radius select, row base
   logic [PHASE_W-1:0] cos_phase;
   logic [IDX_W-1:0]   sin_idx, cos_idx;
   logic [VIDX_W-1:0]  nn, rn, base;
   logic [CNT_W-1:0]   s_next;
   logic [CNT_W:0]     off;

   logic               s1_valid_ff;
   logic               s1_res_ff, s1_kind_ff, s1_last_ff, s1_ring0_ff;
   logic [1:0]         s1_sec_ff;
   logic [RAD_W-1:0]   s1_r_ff;
   logic [MAG_W-1:0]   s1_cmag_ff, s1_smag_ff;
   logic               s1_cneg_ff, s1_sneg_ff;
   logic [VIDX_W-1:0]  s1_row0_ff;
   logic [CNT_W:0]     s1_off_ff;

   // stage 2: products and final index
   logic               s2_valid_ff;
   logic               s2_res_ff, s2_kind_ff, s2_last_ff, s2_ring0_ff;
   logic [1:0]         s2_sec_ff;
   logic               s2_cneg_ff, s2_sneg_ff;
   logic [PROD_W-1:0]  s2_xprod_ff, s2_yprod_ff;
   logic [VIDX_W-1:0]  s2_vidx_ff;

   // output assembly
   logic [PROD_W-1:0]        xr, yr;
   logic [VAL_W-1:0]         xmag, ymag;
   logic signed [VAL_W-1:0]  x_val, y_val;

   logic                     out_valid_ff;
   logic                     out_res_ff, out_kind_ff, out_last_ff;
   logic signed [VAL_W-1:0]  out_x_ff, out_y_ff, out_nx_ff, out_ny_ff, out_nz_ff;
   logic signed [Z_W-1:0]    out_z_ff;
   logic [VIDX_W-1:0]        out_vidx_ff;

   // whole back pipe moves together unless the output is held
   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   assign cos_phase = head_cmd.phase + QUARTER_TURN;

   always_comb begin
      sin_idx = {1'b0, head_cmd.phase[PHASE_W-3 -: TABLE_BITS]};
      if (head_cmd.phase[PHASE_W-2]) begin
         sin_idx = IDX_W'(ROM_Q) - sin_idx;
      end
      cos_idx = {1'b0, cos_phase[PHASE_W-3 -: TABLE_BITS]};
      if (cos_phase[PHASE_W-2]) begin
         cos_idx = IDX_W'(ROM_Q) - cos_idx;
      end
   end

   always_comb begin
      nn = VIDX_W'(head_cmd.n) * VIDX_W'(head_cmd.n);
      rn = VIDX_W'(head_cmd.ring) * VIDX_W'(head_cmd.n);
      case (head_cmd.section)
         SEC_BOTTOM: begin
            base = '0;
         end
         SEC_TUBE: begin
            base = nn;
         end
         default: begin
            base = nn + (VIDX_W'(head_cmd.n) << 1);
         end
      endcase
      s_next = (({1'b0, head_cmd.sector} + 8'd1) >= {1'b0, head_cmd.n}) ?
               '0 : head_cmd.sector + CNT_W'(1);
      // corners walk the quad: lower row, lower next, upper next twice, upper, lower
      case (head_cmd.corner)
         3'd0, 3'd5: begin
            off = {1'b0, head_cmd.sector};
         end
         3'd1: begin
            off = {1'b0, s_next};
         end
         3'd2, 3'd3: begin
            off = {1'b0, head_cmd.n} + {1'b0, s_next};
         end
         default: begin
            off = {1'b0, head_cmd.n} + {1'b0, head_cmd.sector};
         end
      endcase
   end

   always_comb begin
      xr    = s2_xprod_ff + ROUND_Q;
      yr    = s2_yprod_ff + ROUND_Q;
      xmag  = xr[FRAC_BITS +: VAL_W];
      ymag  = yr[FRAC_BITS +: VAL_W];
      x_val = s2_cneg_ff ? -$signed(xmag) : $signed(xmag);
      y_val = s2_sneg_ff ? -$signed(ymag) : $signed(ymag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_res_ff   <= head_cmd.valid_res;
         s1_kind_ff  <= head_cmd.kind;
         s1_last_ff  <= head_cmd.last;
         s1_sec_ff   <= head_cmd.section;
         s1_ring0_ff <= (head_cmd.ring == '0);
         s1_r_ff     <= (head_cmd.section == SEC_TUBE) ? ONE_Q : head_cmd.radius;
         s1_smag_ff  <= sine_rom[sin_idx];
         s1_cmag_ff  <= sine_rom[cos_idx];
         s1_sneg_ff  <= head_cmd.phase[PHASE_W-1];
         s1_cneg_ff  <= cos_phase[PHASE_W-1];
         s1_row0_ff  <= base + rn;
         s1_off_ff   <= off;

         s2_res_ff   <= s1_res_ff;
         s2_kind_ff  <= s1_kind_ff;
         s2_last_ff  <= s1_last_ff;
         s2_sec_ff   <= s1_sec_ff;
         s2_ring0_ff <= s1_ring0_ff;
         s2_cneg_ff  <= s1_cneg_ff;
         s2_sneg_ff  <= s1_sneg_ff;
         s2_xprod_ff <= PROD_W'(s1_r_ff) * PROD_W'(s1_cmag_ff);
         s2_yprod_ff <= PROD_W'(s1_r_ff) * PROD_W'(s1_smag_ff);
         s2_vidx_ff  <= s1_row0_ff + VIDX_W'(s1_off_ff);

         out_res_ff  <= s2_res_ff;
         out_kind_ff <= s2_kind_ff;
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_z_ff    <= '0;
         out_nx_ff   <= '0;
         out_ny_ff   <= '0;
         out_nz_ff   <= '0;
         out_vidx_ff <= '0;
         out_last_ff <= 1'b0;
         if (s2_res_ff && (s2_kind_ff == KIND_INDEX)) begin
            out_vidx_ff <= s2_vidx_ff;
            out_last_ff <= s2_last_ff;
         end else if (s2_res_ff) begin
            out_x_ff <= x_val;
            out_y_ff <= y_val;
            case (s2_sec_ff)
               SEC_BOTTOM: begin
                  out_z_ff  <= -$signed(HALF_Q);
                  out_nz_ff <= -$signed(VAL_W'(ONE_Q));
               end
               SEC_TUBE: begin
                  out_z_ff  <= s2_ring0_ff ? -$signed(HALF_Q) : $signed(HALF_Q);
                  out_nx_ff <= x_val;
                  out_ny_ff <= y_val;
               end
               default: begin
                  out_z_ff  <= $signed(HALF_Q);
                  out_nz_ff <= $signed(VAL_W'(ONE_Q));
               end
            endcase
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_valid_res    = out_res_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_pos_x        = out_x_ff;
   assign rsp_pos_y        = out_y_ff;
   assign rsp_pos_z        = out_z_ff;
   assign rsp_norm_x       = out_nx_ff;
   assign rsp_norm_y       = out_ny_ff;
   assign rsp_norm_z       = out_nz_ff;
   assign rsp_vertex_index = out_vidx_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/cylinder_mesh_generator.sv
// cylinder_mesh_generator: top level of the cylinder mesh generator
// depends on cmg_pkg, cmg_front, cmg_queue, cmg_back
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      req_restart
//   rsp      out        rsp_valid / rsp_stall      valid_res, kind, pos, norm, vertex_index, last
//   csr      in         csr_valid / csr_ready      csr_index, csr_wdata
//
// one transfer per cycle in and out while rsp_stall is low; an item passes from its req
// transfer through the queue entry, then the stage 1 table read, the stage 2 multiply and
// the rounding into the rsp output register, from which its rsp transfer is made
// reset is synchronous: registers go to their defaults and the generator is idle,
// so items give all-zero results until one carries restart; no clearing pass
// rsp_stall freezes the back pipe; the two-entry queue then fills and req_stall rises
`default_nettype none

module cylinder_mesh_generator import cmg_pkg::*; #(
   parameter int MAX_RES    = 64,
   parameter int TABLE_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_restart,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid_res,
   output logic                       rsp_kind,
   output logic signed [VAL_W-1:0]    rsp_pos_x,
   output logic signed [VAL_W-1:0]    rsp_pos_y,
   output logic signed [Z_W-1:0]      rsp_pos_z,
   output logic signed [VAL_W-1:0]    rsp_norm_x,
   output logic signed [VAL_W-1:0]    rsp_norm_y,
   output logic signed [VAL_W-1:0]    rsp_norm_z,
   output logic [VIDX_W-1:0]          rsp_vertex_index,
   output logic                       rsp_last,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_wdata
);

   logic [CNT_W-1:0]   ring_count_ff;
   logic [PHASE_W-1:0] angle_step_ff;
   logic [RAD_W-1:0]   radius_step_ff;

   logic    push, pop, queue_full, head_valid;
   cmd_type push_cmd, head_cmd;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff  <= RING_COUNT_RST;
         angle_step_ff  <= ANGLE_STEP_RST;
         radius_step_ff <= RADIUS_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RING_COUNT: begin
               ring_count_ff <= csr_wdata[CNT_W-1:0];
            end
            CSR_ANGLE_STEP: begin
               angle_step_ff <= csr_wdata[PHASE_W-1:0];
            end
            CSR_RADIUS_STEP: begin
               radius_step_ff <= csr_wdata[RAD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // front: takes items, classifies them and steps the mesh counters
   cmg_front #(
      .MAX_RES (MAX_RES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .ring_count  (ring_count_ff),
      .angle_step  (angle_step_ff),
      .radius_step (radius_step_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decouples the counters from output back-pressure
   cmg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: trig lookup, scaling, index math and the output register
   cmg_back #(
      .TABLE_BITS (TABLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/core/cmg_checker.sv
// cmg_checker: port-level assertions for the cylinder mesh generator, bound to the top level
// depends on cmg_pkg and cylinder_mesh_generator
`default_nettype none

module cmg_checker import cmg_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_valid_res,
   input wire logic                     rsp_kind,
   input wire logic signed [VAL_W-1:0]  rsp_pos_x,
   input wire logic signed [Z_W-1:0]    rsp_pos_z,
   input wire logic signed [VAL_W-1:0]  rsp_norm_x,
   input wire logic signed [VAL_W-1:0]  rsp_norm_z,
   input wire logic [VIDX_W-1:0]        rsp_vertex_index,
   input wire logic                     rsp_last
);

   // a held result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // an index result carries no geometry
   a_index_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res && (rsp_kind == KIND_INDEX)
      |-> (rsp_pos_x == '0) && (rsp_pos_z == '0) && (rsp_norm_x == '0) && (rsp_norm_z == '0))
      else $error("index result with nonzero geometry");

   // a vertex sits on one of the two end planes and never ends the mesh
   a_vertex_z : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res && (rsp_kind == KIND_VERTEX)
      |-> ((rsp_pos_z == $signed(HALF_Q)) || (rsp_pos_z == -$signed(HALF_Q))) && !rsp_last)
      else $error("vertex with bad z or last flag");

   // an idle result, after reset or after the mesh ends, is zero in kind, last, index and z
   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res
      |-> (rsp_kind == KIND_VERTEX) && !rsp_last && (rsp_vertex_index == '0)
          && (rsp_pos_z == '0))
      else $error("idle result not zero");

endmodule

bind cylinder_mesh_generator cmg_checker u_cmg_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
// tb: self-checking testbench for the cylinder mesh generator, clock, reset and stimulus
// depends on cmg_pkg and cylinder_mesh_generator; carries its own mesh predictor
`timescale 1ns / 1ps

module tb;
   import cmg_pkg::*;

   // matches the block's default parameters
   localparam int MESH_MAX_RES  = 64;
   localparam int ROM_BITS      = 8;
   localparam int UNIT          = 1 << FRAC_BITS;
   localparam int HALF_UNIT     = UNIT / 2;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int PIPE_DRAIN    = 8;
   localparam int END_DRAIN     = 24;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_CAP     = 30;

   // index with no register behind it, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // sender idle patterns
   localparam int GAP_NONE  = 0;
   localparam int GAP_SHORT = 1;
   localparam int GAP_LONG  = 2;

   // receiver stall patterns
   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   typedef struct packed {
      logic              valid_res;
      logic              kind;
      logic [VAL_W-1:0]  pos_x;
      logic [VAL_W-1:0]  pos_y;
      logic [Z_W-1:0]    pos_z;
      logic [VAL_W-1:0]  norm_x;
      logic [VAL_W-1:0]  norm_y;
      logic [VAL_W-1:0]  norm_z;
      logic [VIDX_W-1:0] vertex_index;
      logic              last;
   } mesh_item_type;

   // dut ports, inputs known from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic                  rsp_valid_res;
   logic                  rsp_kind;
   logic [VAL_W-1:0]      rsp_pos_x;
   logic [VAL_W-1:0]      rsp_pos_y;
   logic [Z_W-1:0]        rsp_pos_z;
   logic [VAL_W-1:0]      rsp_norm_x;
   logic [VAL_W-1:0]      rsp_norm_y;
   logic [VAL_W-1:0]      rsp_norm_z;
   logic [VIDX_W-1:0]     rsp_vertex_index;
   logic                  rsp_last;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata   = '0;

   // stimulus and expected results
   logic          restart_q[$];
   mesh_item_type expected_q[$];

   // predictor copy of the registers
   logic [CNT_W-1:0]   cfg_ring_count  = RING_COUNT_RST;
   logic [PHASE_W-1:0] cfg_angle_step  = ANGLE_STEP_RST;
   logic [RAD_W-1:0]   cfg_radius_step = RADIUS_STEP_RST;

   // predictor copy of the walk state, idle until a restart
   int unsigned        gen_section = 0;
   int unsigned        gen_ring    = 0;
   int unsigned        gen_sector  = 0;
   int unsigned        gen_corner  = 0;
   logic [PHASE_W-1:0] gen_phase   = '0;
   int unsigned        gen_radius  = 0;
   bit                 gen_indices = 1'b0;
   bit                 gen_done    = 1'b1;

   logic [FRAC_BITS:0] sine_rom [0:(1 << ROM_BITS)];

   // bookkeeping
   int unsigned   cycle_count    = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   sent_items     = 0;
   int unsigned   random_items   = 0;
   int unsigned   checked_items  = 0;
   int unsigned   meshes_done    = 0;
   int unsigned   csr_writes     = 0;
   int unsigned   phases_run     = 0;
   int            gap_mode       = GAP_NONE;
   int            stall_mode     = STALL_NONE;
   int unsigned   burst_left     = 0;
   int unsigned   gap_left       = 0;
   int unsigned   stall_tick     = 0;
   mesh_item_type seen_item;
   mesh_item_type want_item;

   cylinder_mesh_generator #(
      .MAX_RES    (MESH_MAX_RES),
      .TABLE_BITS (ROM_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // quarter-wave entry k: Taylor series of sin in Q30, rounded to Q1.14
   function automatic logic [FRAC_BITS:0] quarter_sine(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] rounded;
      x    = (HALF_PI_Q30 * 64'(k)) >> ROM_BITS;
      x2   = (x * x) >> 30;
      acc  = x;
      term = x;
      for (int unsigned n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      // the last entries can wrap below zero, those read as zero
      if (acc > (64'd1 << 31)) begin
         acc = 64'd0;
      end
      rounded = ((acc << FRAC_BITS) + (64'd1 << 29)) >> 30;
      if (rounded > 64'(UNIT)) begin
         rounded = 64'(UNIT);
      end
      return rounded[FRAC_BITS:0];
   endfunction

   // table sine, top two phase bits pick the quadrant, no interpolation
   function automatic int sine_of(input logic [PHASE_W-1:0] ph);
      logic [ROM_BITS:0] slot;
      int                mag;
      slot = {1'b0, ph[PHASE_W-3 -: ROM_BITS]};
      if (ph[PHASE_W-2]) begin
         slot = (ROM_BITS+1)'(1 << ROM_BITS) - slot;
      end
      mag = int'(sine_rom[slot]);
      return ph[PHASE_W-1] ? -mag : mag;
   endfunction

   // radius times a table value, rounded half away from zero
   function automatic int scale_q(input int unsigned rad, input int c);
      longint unsigned mag;
      mag = (c < 0) ? longint'(-c) : longint'(c);
      mag = (longint'(rad) * mag + longint'(HALF_UNIT)) >> FRAC_BITS;
      return (c < 0) ? -int'(mag) : int'(mag);
   endfunction

   function automatic int unsigned effective_res(input logic [CNT_W-1:0] rc);
      if (rc < MIN_RES) begin
         return int'(MIN_RES);
      end
      if (int'(rc) > MESH_MAX_RES) begin
         return MESH_MAX_RES;
      end
      return int'(rc);
   endfunction

   // items from a restart to the final index
   function automatic int unsigned mesh_length(input int unsigned n);
      return 2 * n * n + 2 * n + 6 * (2 * (n - 1) * n + n);
   endfunction

   // nested counters: corner, sector, ring, section, then vertices to indices to done
   function automatic void walk_forward(input int unsigned n);
      int unsigned rows;
      if (gen_indices) begin
         gen_corner++;
         if (gen_corner < int'(CORNERS)) begin
            return;
         end
         gen_corner = 0;
         rows = (gen_section == SEC_TUBE) ? 1 : n - 1;
      end else begin
         rows = (gen_section == SEC_TUBE) ? 2 : n;
         gen_phase = gen_phase + cfg_angle_step;
      end
      gen_sector++;
      if (gen_sector < n) begin
         return;
      end
      gen_sector = 0;
      gen_phase  = '0;
      gen_ring++;
      gen_radius = gen_radius + cfg_radius_step;
      if (gen_radius > UNIT) begin
         gen_radius = UNIT;
      end
      if (gen_ring < rows) begin
         return;
      end
      gen_ring   = 0;
      gen_radius = 0;
      gen_section++;
      if (gen_section <= SEC_TOP) begin
         return;
      end
      gen_section = SEC_BOTTOM;
      if (gen_indices) begin
         gen_done = 1'b1;
      end else begin
         gen_indices = 1'b1;
      end
   endfunction

   // result of one accepted item, advances the predictor state
   function automatic mesh_item_type next_mesh_item(input logic restart);
      mesh_item_type r;
      int unsigned   n;
      int unsigned   rad;
      int unsigned   base;
      int unsigned   s1;
      int unsigned   row0;
      int unsigned   row1;
      int unsigned   vidx;
      int            cx;
      int            cy;
      r = '0;
      if (restart) begin
         gen_section = SEC_BOTTOM;
         gen_ring    = 0;
         gen_sector  = 0;
         gen_corner  = 0;
         gen_phase   = '0;
         gen_radius  = 0;
         gen_indices = 1'b0;
         gen_done    = 1'b0;
      end
      n = effective_res(cfg_ring_count);
      if (!gen_done) begin
         r.valid_res = 1'b1;
         if (!gen_indices) begin
            rad = (gen_section == SEC_TUBE) ? UNIT : gen_radius;
            cx  = scale_q(rad, sine_of(gen_phase + QUARTER_TURN));
            cy  = scale_q(rad, sine_of(gen_phase));
            r.kind  = KIND_VERTEX;
            r.pos_x = VAL_W'(cx);
            r.pos_y = VAL_W'(cy);
            if (gen_section == SEC_BOTTOM) begin
               r.pos_z  = Z_W'(-HALF_UNIT);
               r.norm_z = VAL_W'(-UNIT);
            end else if (gen_section == SEC_TUBE) begin
               r.pos_z  = (gen_ring == 0) ? Z_W'(-HALF_UNIT) : Z_W'(HALF_UNIT);
               r.norm_x = VAL_W'(cx);
               r.norm_y = VAL_W'(cy);
            end else begin
               r.pos_z  = Z_W'(HALF_UNIT);
               r.norm_z = VAL_W'(UNIT);
            end
         end else begin
            base = (gen_section == SEC_BOTTOM) ? 0
                 : (gen_section == SEC_TUBE)   ? n * n
                 : n * n + 2 * n;
            s1   = (gen_sector + 1 >= n) ? 0 : gen_sector + 1;
            row0 = base + gen_ring * n;
            row1 = row0 + n;
            // corners of a quad: two triangles sharing the diagonal
            case (gen_corner)
               0, 5:    vidx = row0 + gen_sector;
               1:       vidx = row0 + s1;
               2, 3:    vidx = row1 + s1;
               default: vidx = row1 + gen_sector;
            endcase
            r.kind         = KIND_INDEX;
            r.vertex_index = VIDX_W'(vidx);
            r.last = (gen_section == SEC_TOP && gen_ring + 2 >= n &&
                      gen_sector + 1 >= n && gen_corner == LAST_CORNER);
         end
         walk_forward(n);
      end
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] data);
      case (idx)
         CSR_RING_COUNT:  cfg_ring_count  = data[CNT_W-1:0];
         CSR_ANGLE_STEP:  cfg_angle_step  = data[PHASE_W-1:0];
         CSR_RADIUS_STEP: cfg_radius_step = data[RAD_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // driver: bursts of transfers from restart_q with random gaps between
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         // the item on the port was taken at this edge
         if (req_valid && !req_stall) begin
            expected_q.insert(expected_q.size(), next_mesh_item(req_restart));
            sent_items++;
         end
         // a stalled payload holds, otherwise pick what comes next
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (restart_q.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_restart <= restart_q.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  case (gap_mode)
                     GAP_SHORT: begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 3);
                     end
                     GAP_LONG: begin
                        burst_left = $urandom_range(1, 4);
                        gap_left   = $urandom_range(1, 12);
                     end
                     default: begin
                        burst_left = 64;
                        gap_left   = 0;
                     end
                  endcase
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver stall pattern
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         case (stall_mode)
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 6);
            STALL_PERIODIC: rsp_stall <= ((stall_tick % 11) >= 7);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every result transfer against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                  $realtime, checked_items, what, got_v, want_v);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_item = '{rsp_valid_res, rsp_kind, rsp_pos_x, rsp_pos_y, rsp_pos_z,
                       rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_vertex_index, rsp_last};
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected, valid_res", seen_item.valid_res, 0);
         end else begin
            want_item = expected_q.pop_front();
            if (seen_item.valid_res !== want_item.valid_res)
               report_mismatch("valid_res", seen_item.valid_res, want_item.valid_res);
            if (seen_item.kind !== want_item.kind)
               report_mismatch("kind", seen_item.kind, want_item.kind);
            if (seen_item.pos_x !== want_item.pos_x)
               report_mismatch("pos_x", seen_item.pos_x, want_item.pos_x);
            if (seen_item.pos_y !== want_item.pos_y)
               report_mismatch("pos_y", seen_item.pos_y, want_item.pos_y);
            if (seen_item.pos_z !== want_item.pos_z)
               report_mismatch("pos_z", seen_item.pos_z, want_item.pos_z);
            if (seen_item.norm_x !== want_item.norm_x)
               report_mismatch("norm_x", seen_item.norm_x, want_item.norm_x);
            if (seen_item.norm_y !== want_item.norm_y)
               report_mismatch("norm_y", seen_item.norm_y, want_item.norm_y);
            if (seen_item.norm_z !== want_item.norm_z)
               report_mismatch("norm_z", seen_item.norm_z, want_item.norm_z);
            if (seen_item.vertex_index !== want_item.vertex_index)
               report_mismatch("vertex_index", seen_item.vertex_index, want_item.vertex_index);
            if (seen_item.last !== want_item.last)
               report_mismatch("last", seen_item.last, want_item.last);
            if (want_item.last) begin
               meshes_done++;
            end
         end
         checked_items++;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one register write over the csr channel, predictor follows at the transfer
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   // a run of items, optionally opened by a restart, with rare stray restarts
   task automatic queue_run(input bit fresh, input int unsigned count,
                            input int unsigned noise);
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == 0 && fresh) begin
            restart_q.insert(restart_q.size(), 1'b1);
         end else begin
            restart_q.insert(restart_q.size(), noise != 0 && $urandom_range(1, noise) == 1);
         end
      end
   endtask

   // sender holds off until every expected result is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      while (restart_q.size() != 0 || req_valid || expected_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // timeout
   // ---------------------------------------------------------------------
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_q.size());
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned pick;
      int unsigned n_pick;
      int unsigned n_eff;
      int unsigned run_len;
      int unsigned noise;
      logic [CSR_DAT_W-1:0] data;

      for (int unsigned k = 0; k <= (1 << ROM_BITS); k++) begin
         sine_rom[k] = quarter_sine(k);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: idle after reset gives zero results, then a restart on the
      // default registers, then a restart in the middle of a mesh
      queue_run(1'b0, 2, 0);
      queue_run(1'b1, 6, 0);
      queue_run(1'b1, 3, 0);
      settle();

      // resolution below the minimum, widest angle step, radius that saturates
      write_register(CSR_RING_COUNT, 16'h0000);
      write_register(CSR_ANGLE_STEP, 16'hFFFF);
      write_register(CSR_RADIUS_STEP, 16'h4000);
      queue_run(1'b1, 8, 0);
      settle();

      // registers changed mid-mesh: resolution above the maximum (all data bits
      // set), zero angle step, radius step with its dropped top bit, unmapped index
      write_register(CSR_RING_COUNT, 16'hFFFF);
      write_register(CSR_RADIUS_STEP, 16'hFFFF);
      write_register(CSR_ANGLE_STEP, 16'h0000);
      write_register(CSR_UNMAPPED, 16'h5A5A);
      queue_run(1'b0, 5, 0);

      // random phases: mostly whole small meshes, some cut short, some noisy
      while (random_items < RANDOM_ITEMS) begin
         settle();
         phases_run++;
         gap_mode   = $urandom_range(GAP_NONE, GAP_LONG);
         stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);

         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            n_pick = $urandom_range(3, 4);
         end else if (pick < 14) begin
            n_pick = $urandom_range(5, 12);
         end else if (pick < 16) begin
            n_pick = $urandom_range(13, MESH_MAX_RES);
         end else if (pick < 18) begin
            n_pick = $urandom_range(0, 2);
         end else begin
            n_pick = $urandom_range(MESH_MAX_RES + 1, 127);
         end
         n_eff = effective_res(CNT_W'(n_pick));

         // some phases keep the registers and carry on the mesh in flight
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 2) != 0) begin
               data = {($urandom_range(0, 5) == 0) ? 9'($urandom) : 9'd0, CNT_W'(n_pick)};
               write_register(CSR_RING_COUNT, data);
            end
            if ($urandom_range(0, 2) != 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 6)      data = 16'((65536 + n_eff / 2) / n_eff);
               else if (pick < 8) data = 16'($urandom);
               else if (pick < 9) data = 16'h0000;
               else               data = 16'hFFFF;
               write_register(CSR_ANGLE_STEP, data);
            end
            if ($urandom_range(0, 2) != 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 6)      data = 16'((UNIT + (n_eff - 1) / 2) / (n_eff - 1));
               else if (pick < 8) data = 16'($urandom);
               else if (pick < 9) data = 16'h0000;
               else               data = 16'(UNIT);
               write_register(CSR_RADIUS_STEP, data);
            end
         end

         // length from the resolution the block will really use
         n_eff   = effective_res(cfg_ring_count);
         run_len = mesh_length(n_eff) + $urandom_range(0, 4);
         if (run_len > 400) begin
            run_len = $urandom_range(40, 400);
         end
         noise = ($urandom_range(0, 3) == 0) ? 40 : 0;
         queue_run($urandom_range(0, 5) != 0, run_len, noise);
         random_items += run_len;
      end

      // all stimulus in, wait for the last results and for anything stray
      settle();
      repeat (END_DRAIN) @(posedge clock);

      $display("%0d items sent in %0d random phases, %0d results checked, %0d meshes ended",
               sent_items, phases_run, checked_items, meshes_done);
      $display("%0d register writes, resolutions from clamped low to clamped high",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
